/* sv/assert_macros.svh */
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/sfcc_pkg.sv */
`timescale 1ns / 1ps

package sfcc_pkg;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'h00;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_SCALE  = 15'd16500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4000;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  // Raw contents of one completed frame.
  typedef struct packed {
    logic        status;
    logic        temp_valid;
    logic [15:0] raw_t;
    logic [15:0] raw_h;
  } frame_t;

  // CRC-8, MSB first, one byte folded in.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* sv/sfcc_if.sv */
`timescale 1ns / 1ps

interface sfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink (input valid, rx_byte, frame_start, output ready);
endinterface

interface sfcc_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic [15:0]        raw_temperature;
  logic [15:0]        raw_humidity;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic               temperature_valid;

  modport source (output valid, status, raw_temperature, raw_humidity, temperature_centi,
                  humidity_centi, temperature_valid, input ready);
  modport sink (input valid, status, raw_temperature, raw_humidity, temperature_centi,
                humidity_centi, temperature_valid, output ready);
endinterface

/* sv/sfcc_parse.sv */
`timescale 1ns / 1ps

// Byte-level frame tracker: position, running CRC and the held words.
module sfcc_parse #(
  parameter int CRC_SPAN_BYTES = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mode,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  output logic                emit,
  output sfcc_pkg::frame_t    frame
);

  localparam int OFF_W = (CRC_SPAN_BYTES + 1 > 1) ? $clog2(CRC_SPAN_BYTES + 1) : 1;
  localparam logic [OFF_W-1:0] CRC_OFF   = OFF_W'(CRC_SPAN_BYTES);
  localparam logic [OFF_W-1:0] LAST_DATA = OFF_W'(CRC_SPAN_BYTES - 1);

  logic [OFF_W-1:0] off_r, off_nxt;
  logic             seg_r, seg_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic             fail_r, fail_nxt;
  logic [7:0]       whb_r, whb_nxt;
  logic [15:0]      temp_r, temp_nxt;
  logic [15:0]      hum_r, hum_nxt;

  logic             restart;
  logic             two_seg;
  logic [OFF_W-1:0] off_c;
  logic             seg_c;
  logic [7:0]       crc_c;
  logic             fail_c;
  logic             fail_chk;
  logic [7:0]       hi_c;

  always_comb begin
    restart  = frame_start || (seg_r && mode);
    two_seg  = !mode;
    off_c    = restart ? '0 : off_r;
    seg_c    = restart ? 1'b0 : seg_r;
    crc_c    = restart ? sfcc_pkg::CRC_INIT : crc_r;
    fail_c   = restart ? 1'b0 : fail_r;
    hi_c     = (off_c == '0) ? 8'h00 : whb_r;
    fail_chk = fail_c || (crc_c != rx_byte);

    off_nxt  = off_r;
    seg_nxt  = seg_r;
    crc_nxt  = crc_r;
    fail_nxt = fail_r;
    whb_nxt  = whb_r;
    temp_nxt = temp_r;
    hum_nxt  = hum_r;
    emit     = 1'b0;

    frame.status     = fail_chk;
    frame.temp_valid = two_seg;
    frame.raw_t      = two_seg ? temp_r : 16'h0000;
    frame.raw_h      = hum_r;

    if (take) begin
      if (off_c != CRC_OFF) begin
        // Data byte of the current segment.
        crc_nxt  = sfcc_pkg::crc8_byte(crc_c, rx_byte);
        whb_nxt  = rx_byte;
        off_nxt  = off_c + OFF_W'(1);
        seg_nxt  = seg_c;
        fail_nxt = fail_c;
        if (off_c == LAST_DATA) begin
          if (two_seg && !seg_c) begin
            temp_nxt = {hi_c, rx_byte};
          end else begin
            hum_nxt = {hi_c, rx_byte};
          end
        end
      end else begin
        crc_nxt = sfcc_pkg::CRC_INIT;
        if (two_seg && !seg_c) begin
          // End of the temperature segment; humidity follows.
          seg_nxt  = 1'b1;
          off_nxt  = '0;
          fail_nxt = fail_chk;
        end else begin
          emit     = 1'b1;
          seg_nxt  = 1'b0;
          off_nxt  = '0;
          fail_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      seg_r  <= 1'b0;
      crc_r  <= sfcc_pkg::CRC_INIT;
      fail_r <= 1'b0;
      whb_r  <= 8'h00;
      temp_r <= 16'h0000;
      hum_r  <= 16'h0000;
    end else begin
      off_r  <= off_nxt;
      seg_r  <= seg_nxt;
      crc_r  <= crc_nxt;
      fail_r <= fail_nxt;
      whb_r  <= whb_nxt;
      temp_r <= temp_nxt;
      hum_r  <= hum_nxt;
    end
  end

endmodule

/* sv/sfcc_conv.sv */
`timescale 1ns / 1ps

// Scales raw words to hundredths. The division by 65535 is exact: the
// quotient estimate x>>16 is low by at most one, and the remainder
// (x mod 65536) + estimate stays below twice 65535.
module sfcc_conv (
  input  logic               temp_valid,
  input  logic [15:0]        raw_t,
  input  logic [15:0]        raw_h,
  output logic signed [14:0] temp_centi,
  output logic [13:0]        hum_centi
);

  logic [29:0] hum_prod;
  logic [13:0] hum_q0;
  logic [16:0] hum_rem;
  logic [30:0] temp_prod;
  logic [14:0] temp_q0;
  logic [16:0] temp_rem;
  logic [14:0] temp_q;

  always_comb begin
    hum_prod  = 30'(raw_h) * 30'(sfcc_pkg::HUM_SCALE);
    hum_q0    = hum_prod[29:16];
    hum_rem   = {1'b0, hum_prod[15:0]} + 17'(hum_q0);
    hum_centi = hum_q0 + 14'(hum_rem >= sfcc_pkg::FULL_SCALE);

    temp_prod = 31'(raw_t) * 31'(sfcc_pkg::TEMP_SCALE);
    temp_q0   = temp_prod[30:16];
    temp_rem  = {1'b0, temp_prod[15:0]} + 17'(temp_q0);
    temp_q    = temp_q0 + 15'(temp_rem >= sfcc_pkg::FULL_SCALE);
    temp_centi = temp_valid ? $signed(temp_q - sfcc_pkg::TEMP_OFFSET) : 15'sd0;
  end

endmodule

/* sv/sensor_frame_crc_check_convert_top.sv */
`timescale 1ns / 1ps
// A frame's result is registered in stage one and then in the output register that drives out_ch;
// a stalled output register holds the result in stage one.
// One byte transaction per cycle unless input stalls; the tracker and the scaling are combinational.
// A stalled result holds the frame register; input stalls only when both result stages are full.
// Reset (rst_n low at a rising edge, synchronous): frame position, CRC, failure flag and
// held words clear, frame_mode returns to 0 and no result is pending.
module sensor_frame_crc_check_convert_top #(
  parameter int CRC_SPAN_BYTES = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  sfcc_in_if.sink     in_ch,
  sfcc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_wdata
);

  // Frame mode register: 0 = temperature and humidity, 1 = humidity only.
  logic mode_r;

  // Stage one holds a completed frame's raw contents; stage two is the output register.
  logic               s1_valid_r;
  sfcc_pkg::frame_t   s1_frame_r;
  logic               out_valid_r;
  logic               out_status_r;
  logic [15:0]        out_raw_t_r;
  logic [15:0]        out_raw_h_r;
  logic signed [14:0] out_temp_c_r;
  logic [13:0]        out_hum_c_r;
  logic               out_tv_r;

  logic               in_take;
  logic               s1_adv;
  logic               emit;
  sfcc_pkg::frame_t   frame;
  logic signed [14:0] temp_c;
  logic [13:0]        hum_c;

  // Stage one moves on whenever the output register is empty or being emptied this cycle.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata[0];
    end
  end

  // The frame tracker works on every accepted byte and flags the one that closes a frame.
  sfcc_parse #(
    .CRC_SPAN_BYTES(CRC_SPAN_BYTES)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .mode        (mode_r),
    .take        (in_take),
    .rx_byte     (in_ch.rx_byte),
    .frame_start (in_ch.frame_start),
    .emit        (emit),
    .frame       (frame)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= (in_take && emit) || (s1_valid_r && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && emit) begin
      s1_frame_r <= frame;
    end
  end

  // Scaling to hundredths sits between stage one and the output register.
  sfcc_conv u_conv (
    .temp_valid (s1_frame_r.temp_valid),
    .raw_t      (s1_frame_r.raw_t),
    .raw_h      (s1_frame_r.raw_h),
    .temp_centi (temp_c),
    .hum_centi  (hum_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= s1_frame_r.status;
      out_raw_t_r  <= s1_frame_r.raw_t;
      out_raw_h_r  <= s1_frame_r.raw_h;
      out_temp_c_r <= temp_c;
      out_hum_c_r  <= hum_c;
      out_tv_r     <= s1_frame_r.temp_valid;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.raw_temperature   = out_raw_t_r;
  assign out_ch.raw_humidity      = out_raw_h_r;
  assign out_ch.temperature_centi = out_temp_c_r;
  assign out_ch.humidity_centi    = out_hum_c_r;
  assign out_ch.temperature_valid = out_tv_r;

endmodule

/* sv/sfcc_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfcc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        raw_temperature,
  input logic [15:0]        raw_humidity,
  input logic signed [14:0] temperature_centi,
  input logic [13:0]        humidity_centi,
  input logic               temperature_valid
);

  logic temp_fields_zero;

  assign temp_fields_zero = (raw_temperature == 16'h0000) && (temperature_centi == 15'sd0);

  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  `ASSERT_IMP(a_hum_range, clk, rst_n, out_valid, humidity_centi <= 14'd10000)

  `ASSERT_IMP(a_no_temp_zero, clk, rst_n, out_valid && !temperature_valid, temp_fields_zero)

  `ASSERT_IMP(a_hum_full, clk, rst_n, out_valid && raw_humidity == 16'hFFFF, humidity_centi == 14'd10000)

endmodule

bind sensor_frame_crc_check_convert_top sfcc_checker u_sfcc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .raw_temperature   (out_ch.raw_temperature),
  .raw_humidity      (out_ch.raw_humidity),
  .temperature_centi (out_ch.temperature_centi),
  .humidity_centi    (out_ch.humidity_centi),
  .temperature_valid (out_ch.temperature_valid)
);

/* bench/tb.sv */
`timescale 1ns / 1ps

// Bench for the CRC-checked temperature and humidity frame decoder.
//
// Response bytes are pushed into in_ch one transaction at a time. Decoded readings are
// taken from out_ch. Both sides back off at random, apart from one long stretch in which
// neither side idles. A behavioural copy of the decoder runs alongside the block and
// queues the reading that each frame should produce. Every result transaction is checked
// field by field against the oldest queued reading.
//
// The run has two parts. The first is a short table of hand-picked bytes: extreme words,
// a bad CRC, a restart in the middle of a frame, a frame that follows another without a
// start flag, and a change of frame mode part-way through a frame. The second is a set of
// random phases. Each phase writes frame_mode and then mixes well-formed frames with
// truncated frames and line noise.
module tb;

  localparam int SPAN            = 2;          // data bytes covered by each CRC byte
  localparam int SEG_LEN         = SPAN + 1;
  localparam int SETTLE_CYCLES   = 4;          // pipeline depth plus margin before a write
  localparam int TAIL_CYCLES     = 8;
  localparam int STALL_LIMIT     = 2000;       // cycles without any transaction
  localparam int IDLE_PCT        = 18;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 138;
  localparam int QUIET_FROM      = 700;        // no idling on either side in this window
  localparam int QUIET_TO        = 1000;

  typedef enum logic {
    MODE_TEMP_HUM = 1'b0,
    MODE_HUM_ONLY = 1'b1
  } frame_mode_e;

  typedef enum logic [1:0] {
    BYTE_DATA,
    BYTE_CRC_OK,
    BYTE_CRC_BAD
  } byte_kind_e;

  typedef struct packed {
    logic        status;
    logic [15:0] raw_t;
    logic [15:0] raw_h;
    logic [14:0] temp_c;
    logic [13:0] hum_c;
    logic        temp_valid;
  } reading_t;

  typedef struct packed {
    byte_kind_e  kind;
    logic [7:0]  value;
    logic        start;
    frame_mode_e mode;
    logic        typed;
    reading_t    want;
  } stim_row_t;

  localparam reading_t NO_READING = '0;

  // The directed table. A CRC row takes its byte from the running CRC at the moment it is
  // sent; a bad CRC row flips some of those bits. A reading is written out only where it is
  // obvious from the words; the other frames are left to the behavioural copy.
  localparam stim_row_t DIRECTED [23] = '{
    // All-zero words with good CRCs: the lowest temperature and humidity.
    '{BYTE_DATA,    8'h00, 1'b1, MODE_TEMP_HUM, 1'b0, NO_READING},
    '{BYTE_DATA,    8'h00, 1'b0, MODE_TEMP_HUM, 1'b0, NO_READING},
    '{BYTE_CRC_OK,  8'h00, 1'b0, MODE_TEMP_HUM, 1'b0, NO_READING},
    '{BYTE_DATA,    8'h00, 1'b0, MODE_TEMP_HUM, 1'b0, NO_READING},
    '{BYTE_DATA,    8'h00, 1'b0, MODE_TEMP_HUM, 1'b0, NO_READING},
    '{BYTE_CRC_OK,  8'h00, 1'b0, MODE_TEMP_HUM, 1'b1,
      '{1'b0, 16'h0000, 16'h0000, 15'(-4000), 14'd0, 1'b1}},
    // Two bytes of a frame, then a restart. The new frame carries full-scale words and
    // a corrupted temperature CRC.
    '{BYTE_DATA,    8'h12, 1'b1, MODE_TEMP_HUM, 1'b0, NO_READING},
    '{BYTE_DATA,    8'h34, 1'b0, MODE_TEMP_HUM, 1'b0, NO_READING},
    '{BYTE_DATA,    8'hFF, 1'b1, MODE_TEMP_HUM, 1'b0, NO_READING},
    '{BYTE_DATA,    8'hFF, 1'b0, MODE_TEMP_HUM, 1'b0, NO_READING},
    '{BYTE_CRC_BAD, 8'h00, 1'b0, MODE_TEMP_HUM, 1'b0, NO_READING},
    '{BYTE_DATA,    8'hFF, 1'b0, MODE_TEMP_HUM, 1'b0, NO_READING},
    '{BYTE_DATA,    8'hFF, 1'b0, MODE_TEMP_HUM, 1'b0, NO_READING},
    '{BYTE_CRC_OK,  8'h00, 1'b0, MODE_TEMP_HUM, 1'b1,
      '{1'b1, 16'hFFFF, 16'hFFFF, 15'd12500, 14'd10000, 1'b1}},
    // Humidity-only frame that follows on without a start flag.
    '{BYTE_DATA,    8'h80, 1'b0, MODE_HUM_ONLY, 1'b0, NO_READING},
    '{BYTE_DATA,    8'h00, 1'b0, MODE_HUM_ONLY, 1'b0, NO_READING},
    '{BYTE_CRC_OK,  8'h00, 1'b0, MODE_HUM_ONLY, 1'b1,
      '{1'b0, 16'h0000, 16'h8000, 15'd0, 14'd5000, 1'b0}},
    // Frame begun in humidity-only mode and completed as a two-word frame.
    '{BYTE_DATA,    8'h44, 1'b1, MODE_HUM_ONLY, 1'b0, NO_READING},
    '{BYTE_DATA,    8'h55, 1'b0, MODE_TEMP_HUM, 1'b0, NO_READING},
    '{BYTE_CRC_OK,  8'h00, 1'b0, MODE_TEMP_HUM, 1'b0, NO_READING},
    '{BYTE_DATA,    8'h66, 1'b0, MODE_TEMP_HUM, 1'b0, NO_READING},
    '{BYTE_DATA,    8'h77, 1'b0, MODE_TEMP_HUM, 1'b0, NO_READING},
    '{BYTE_CRC_OK,  8'h00, 1'b0, MODE_TEMP_HUM, 1'b0, NO_READING}
  };

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [0:0] cfg_wdata;

  sfcc_in_if  in_ch ();
  sfcc_out_if out_ch ();

  sensor_frame_crc_check_convert_top #(
    .CRC_SPAN_BYTES(SPAN)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // State of the behavioural copy of the decoder.
  frame_mode_e mode_now;
  int          byte_pos;
  logic [7:0]  crc_acc;
  logic [7:0]  last_byte;
  logic [15:0] temp_word;
  logic [15:0] hum_word;
  logic        crc_bad;

  reading_t readings_due[$];
  int       err_count;
  int       sent_count;
  int       quiet_cycles;
  bit       steady;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // CRC-8, polynomial 0x31, MSB first, with one byte folded in.
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] acc;
    acc = crc ^ b;
    repeat (8) begin
      acc = acc[7] ? ((acc << 1) ^ sfcc_pkg::CRC_POLY) : (acc << 1);
    end
    return acc;
  endfunction

  // A sensor byte, with a bias towards the two extreme values.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Advances the behavioural copy by one accepted byte. When the byte closes a frame,
  // got is set and r holds the reading that the block must produce.
  task automatic track_byte(input logic [7:0] b, input logic start,
                            output logic got, output reading_t r);
    int segs;
    int frame_len;
    int seg;
    int off;
    int t_scaled;
    logic [7:0] hi;
    got = 1'b0;
    r = NO_READING;
    segs = (mode_now == MODE_HUM_ONLY) ? 1 : 2;
    frame_len = SEG_LEN * segs;
    // A start flag, or a position past the end of the current mode's frame, begins anew.
    if (start || byte_pos >= frame_len) begin
      byte_pos = 0;
      crc_acc = sfcc_pkg::CRC_INIT;
      crc_bad = 1'b0;
    end
    seg = byte_pos / SEG_LEN;
    off = byte_pos % SEG_LEN;
    if (off < SPAN) begin
      hi = (off == 0) ? 8'h00 : last_byte;
      crc_acc = crc_fold(crc_acc, b);
      if (off + 1 == SPAN) begin
        if (segs == 2 && seg == 0) begin
          temp_word = {hi, b};
        end else begin
          hum_word = {hi, b};
        end
      end
      last_byte = b;
      byte_pos++;
    end else begin
      if (crc_acc != b) begin
        crc_bad = 1'b1;
      end
      crc_acc = sfcc_pkg::CRC_INIT;
      if (seg + 1 < segs) begin
        byte_pos++;
      end else begin
        got = 1'b1;
        r.status = crc_bad;
        r.temp_valid = (segs == 2);
        r.raw_t = (segs == 2) ? temp_word : 16'h0000;
        r.raw_h = hum_word;
        r.hum_c = 14'((10000 * int'(hum_word)) / 65535);
        t_scaled = (16500 * int'(temp_word)) / 65535 - 4000;
        r.temp_c = (segs == 2) ? 15'(t_scaled) : 15'd0;
        byte_pos = 0;
        crc_acc = sfcc_pkg::CRC_INIT;
        crc_bad = 1'b0;
      end
    end
  endtask

  // Offers one byte on in_ch, after a random gap, and waits for the transaction. On
  // acceptance the behavioural copy advances and any resulting reading is queued. A typed
  // reading from the table takes the place of the computed one.
  task automatic send_byte(input logic [7:0] b, input logic start,
                           input logic typed, input reading_t want);
    logic got;
    reading_t r;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.rx_byte     <= b;
    in_ch.frame_start <= start;
    do @(posedge clk); while (!in_ch.ready);
    track_byte(b, start, got, r);
    if (typed) begin
      readings_due.push_back(want);
    end else if (got) begin
      readings_due.push_back(r);
    end
    sent_count++;
  endtask

  // Sends count random bytes. The first byte carries first_start, and each later byte
  // has a start flag with a probability of start_pct percent.
  task automatic send_burst(input int count, input logic first_start, input int start_pct);
    for (int k = 0; k < count; k++) begin
      send_byte(pick_byte(), (k == 0) ? first_start : ($urandom_range(99) < start_pct),
                1'b0, NO_READING);
    end
  endtask

  // frame_mode is written only when no reading is outstanding and the pipeline has had
  // time to empty. Any partial frame stays in the block, so a write may also fall part-way
  // through a frame.
  task automatic set_mode(input frame_mode_e m);
    in_ch.valid <= 1'b0;
    while (readings_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mode_now = m;
  endtask

  // The sink stalls at random, except in the steady window.
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Every result transaction is checked against the oldest queued reading.
  always @(posedge clk) begin : result_check
    reading_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (readings_due.size() == 0) begin
        $error("result transaction with no reading expected");
        err_count++;
      end else begin
        want = readings_due.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_ch.status);
          err_count++;
        end
        if (out_ch.raw_temperature !== want.raw_t) begin
          $error("raw_temperature: expected %0d, actual %0d", want.raw_t,
                 out_ch.raw_temperature);
          err_count++;
        end
        if (out_ch.raw_humidity !== want.raw_h) begin
          $error("raw_humidity: expected %0d, actual %0d", want.raw_h, out_ch.raw_humidity);
          err_count++;
        end
        if (out_ch.temperature_centi !== want.temp_c) begin
          $error("temperature_centi: expected %0d, actual %0d", $signed(want.temp_c),
                 out_ch.temperature_centi);
          err_count++;
        end
        if (out_ch.humidity_centi !== want.hum_c) begin
          $error("humidity_centi: expected %0d, actual %0d", want.hum_c,
                 out_ch.humidity_centi);
          err_count++;
        end
        if (out_ch.temperature_valid !== want.temp_valid) begin
          $error("temperature_valid: expected %0d, actual %0d", want.temp_valid,
                 out_ch.temperature_valid);
          err_count++;
        end
      end
    end
  end

  // The watchdog ends the run once too many cycles pass without a transaction on either
  // channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    @(posedge clk);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
    end
    $display("tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int phase_end;
    int roll;
    int segs;
    logic first;
    logic [7:0] b;

    err_count  = 0;
    sent_count = 0;
    steady     = 1'b0;
    mode_now   = MODE_TEMP_HUM;
    byte_pos   = 0;
    crc_acc    = sfcc_pkg::CRC_INIT;
    crc_bad    = 1'b0;
    last_byte  = 8'h00;
    temp_word  = 16'h0000;
    hum_word   = 16'h0000;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.rx_byte     <= 8'h00;
    in_ch.frame_start <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. The first frame is complete and in two-word mode, so that no later
    // frame reads a word that was never received.
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].mode != mode_now) begin
        set_mode(DIRECTED[i].mode);
      end
      case (DIRECTED[i].kind)
        BYTE_CRC_OK:  b = crc_acc;
        BYTE_CRC_BAD: b = crc_acc ^ 8'hA5;
        default:      b = DIRECTED[i].value;
      endcase
      send_byte(b, DIRECTED[i].start, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random phases. The first two fix both modes; after that the mode is drawn at random.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 2) begin
        set_mode((ph == 0) ? MODE_HUM_ONLY : MODE_TEMP_HUM);
      end else begin
        set_mode(frame_mode_e'($urandom_range(1)));
      end
      phase_end = sent_count + ITEMS_PER_PHASE;
      while (sent_count < phase_end) begin
        steady = (sent_count >= QUIET_FROM) && (sent_count < QUIET_TO);
        roll = $urandom_range(99);
        if (roll < 75) begin
          // Well-formed frame with random words. Most CRC bytes are right; now and then
          // the start flag is missing.
          segs = (mode_now == MODE_HUM_ONLY) ? 1 : 2;
          first = ($urandom_range(9) != 0);
          for (int s = 0; s < segs; s++) begin
            for (int k = 0; k < SPAN; k++) begin
              send_byte(pick_byte(), first, 1'b0, NO_READING);
              first = 1'b0;
            end
            b = ($urandom_range(99) < 88) ? crc_acc : (crc_acc ^ 8'($urandom_range(255, 1)));
            send_byte(b, 1'b0, 1'b0, NO_READING);
          end
        end else if (roll < 88) begin
          // Burst with a start flag, too short for a two-word frame; a later start flag can discard it.
          send_burst($urandom_range(5, 1), 1'b1, 0);
        end else begin
          send_burst($urandom_range(8, 1), $urandom_range(1), 25);
        end
      end
      steady = 1'b0;
      // About half of the phases end with a short burst that opens a new frame, so the next
      // mode write can fall mid-frame.
      if ($urandom_range(1)) begin
        send_burst($urandom_range(4, 1), 1'b1, 0);
      end
    end

    in_ch.valid <= 1'b0;
    while (readings_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
